// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the packed field store modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/pfs_pkg.sv =====
// Types and constants of the packed 10-bit field store.
package pfs_pkg;

  localparam int FIELD_BITS   = 10;
  localparam int WORD_BITS    = 32;
  localparam int PAIR_TOP     = 54;    // 64 - FIELD_BITS: shift of a field at offset 0
  localparam int STRADDLE_OFF = 22;    // offsets above this run into the next word
  localparam logic [FIELD_BITS-1:0] FIELD_MASK = 10'h3FF;

  // Request beat
  typedef struct packed {
    logic       req_type;      // 0 read, 1 write
    logic [6:0] entry_index;
    logic [9:0] write_value;
  } req_t;

  // Result beat
  typedef struct packed {
    logic [9:0] read_value;
    logic       bad_index;
  } rsp_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;   // latch the incoming request
    logic rd_en;    // read both words of the pair
    logic emit;     // load the result register
    logic wr_hi;    // write back the upper word
    logic wr_lo;    // write back the lower word
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic bad;
    logic straddle;
    logic is_write;
    logic out_busy;
  } sts_t;

endpackage

// ===== rtl/pfs_ctrl.sv =====
// Sequencing controller of the packed 10-bit field store.
`include "assert_macros.svh"

module pfs_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pfs_pkg::sts_t sts_i,
  output pfs_pkg::cmd_t cmd_o
);
  import pfs_pkg::*;

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_READ  = 2'd1;
  localparam logic [1:0] S_MERGE = 2'd2;
  localparam logic [1:0] S_WR_LO = 2'd3;

  logic [1:0] state_q, state_d;
  logic       do_write;

  assign do_write   = sts_i.is_write && !sts_i.bad;
  assign in_stall_o = (state_q != S_IDLE);

  // Decode commands and next state
  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = S_READ;
        end
      end
      S_READ: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_MERGE;
      end
      S_MERGE: begin
        // hold until the result register can take the beat
        if (!sts_i.out_busy) begin
          cmd_o.emit  = 1'b1;
          cmd_o.wr_hi = do_write;
          state_d     = (do_write && sts_i.straddle) ? S_WR_LO : S_IDLE;
        end
      end
      S_WR_LO: begin
        cmd_o.wr_lo = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `ASSERT_NEXT(a_accept_reads, clk_i, rst_ni, cmd_o.accept, cmd_o.rd_en, "read not issued after accept")
  `ASSERT_IMPL(a_lo_after_hi, clk_i, rst_ni, cmd_o.wr_lo, $past(cmd_o.wr_hi), "lower write without upper write")
  `ASSERT_IMPL(a_write_emits, clk_i, rst_ni, cmd_o.wr_hi, cmd_o.emit && !sts_i.out_busy, "write-back outside result cycle")

endmodule

// ===== rtl/pfs_dpath.sv =====
// Word store, field extract/merge and result register of the packed field store.
`include "assert_macros.svh"

module pfs_dpath #(
  parameter int ENTRY_COUNT = 96,
  parameter int WORD_COUNT  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  pfs_pkg::req_t in_data_i,
  input  pfs_pkg::cmd_t cmd_i,
  output pfs_pkg::sts_t sts_o,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pfs_pkg::rsp_t out_data_o
);
  import pfs_pkg::*;

  // Only the words that some entry touches are stored; the rest read as zero.
  localparam int NEED_WORDS = (FIELD_BITS * ENTRY_COUNT) / WORD_BITS + 1;
  localparam int MEM_DEPTH  = (WORD_COUNT < NEED_WORDS) ? WORD_COUNT : NEED_WORDS;
  localparam int MEM_AW     = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

  logic [WORD_BITS-1:0] mem [MEM_DEPTH];
  logic [MEM_DEPTH-1:0] vld_q;

  req_t                 req_q;
  logic [WORD_BITS-1:0] hi_q, lo_q;
  logic                 out_valid_q;
  rsp_t                 rsp_q;

  logic [10:0]          first_pos;
  logic [5:0]           hi_idx, lo_idx, wr_idx;
  logic [4:0]           bit_off;
  logic [5:0]           sh;
  logic                 hi_in, lo_in, wr_in, wr_en;
  logic                 bad;
  logic [63:0]          pair, mask, new_pair;
  logic [FIELD_BITS-1:0] rd_field;
  logic [WORD_BITS-1:0] wr_data;
  logic [MEM_AW-1:0]    wr_addr, hi_addr, lo_addr;

  // Latch the request beat
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_q <= in_data_i;
    end
  end

  // Locate the field: top bit position, word and offset
  assign first_pos = 11'(req_q.entry_index) * 11'(FIELD_BITS) + 11'd1;
  assign hi_idx    = first_pos[10:5];
  assign bit_off   = first_pos[4:0];
  assign lo_idx    = hi_idx + 6'd1;
  assign hi_in     = 32'(hi_idx) < MEM_DEPTH;
  assign lo_in     = 32'(lo_idx) < MEM_DEPTH;
  assign hi_addr   = hi_idx[MEM_AW-1:0];
  assign lo_addr   = lo_idx[MEM_AW-1:0];
  assign bad       = 32'(req_q.entry_index) >= ENTRY_COUNT;

  // Extract and merge over the two-word window
  assign sh       = 6'(PAIR_TOP) - {1'b0, bit_off};
  assign pair     = {hi_q, lo_q};
  assign mask     = 64'(FIELD_MASK) << sh;
  assign new_pair = (pair & ~mask) | ((64'(req_q.write_value) << sh) & mask);
  assign rd_field = FIELD_BITS'((pair & mask) >> sh);

  // Select the write-back word
  assign wr_idx  = cmd_i.wr_hi ? hi_idx : lo_idx;
  assign wr_in   = cmd_i.wr_hi ? hi_in : lo_in;
  assign wr_addr = wr_idx[MEM_AW-1:0];
  assign wr_data = cmd_i.wr_hi ? new_pair[63:32] : new_pair[31:0];
  assign wr_en   = (cmd_i.wr_hi || cmd_i.wr_lo) && wr_in;

  // Word store: one write port, two registered read ports
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd_i.rd_en) begin
      hi_q <= (hi_in && vld_q[hi_addr]) ? mem[hi_addr] : '0;
      lo_q <= (lo_in && vld_q[lo_addr]) ? mem[lo_addr] : '0;
    end
  end

  // Mark written words; unwritten words read as zero
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (wr_en) begin
      vld_q[wr_addr] <= 1'b1;
    end
  end

  // Result register: load on emit, drop once the beat is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      rsp_q.read_value <= (bad || req_q.req_type) ? '0 : rd_field;
      rsp_q.bad_index  <= bad;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = rsp_q;

  assign sts_o.bad      = bad;
  assign sts_o.straddle = bit_off > 5'(STRADDLE_OFF);
  assign sts_o.is_write = req_q.req_type;
  assign sts_o.out_busy = out_valid_q && out_stall_i;

  `ASSERT_IMPL(a_lo_needs_straddle, clk_i, rst_ni, cmd_i.wr_lo, sts_o.straddle && sts_o.is_write && !sts_o.bad, "lower write-back on a non-straddling request")
  `ASSERT_IMPL(a_no_bad_write, clk_i, rst_ni, cmd_i.wr_hi, !bad, "write-back on an out-of-range index")

endmodule

// ===== rtl/packed_10bit_field_store_top.sv =====
// Top level of the packed 10-bit field store.
// Holds ENTRY_COUNT 10-bit entries packed most significant bit first into 32-bit
// words, entry i at bit positions 10*i+1 .. 10*i+10; entries may straddle a word
// boundary. Each request beat reads or writes one entry and returns one result
// beat. With no output stall a request steps through accept, read of both words,
// and merge and result before the next accept; a write whose entry straddles two
// words adds a lower-word write, since the single write port of the word store
// writes the two words in turn. A result waiting in the output register does not
// block acceptance of the next request, but that request holds in its merge cycle
// until the waiting beat is taken. The store is zero after reset through per-word
// valid bits, so no clearing pass is needed. An index at or beyond ENTRY_COUNT
// sets bad_index, returns zero and writes nothing; words beyond WORD_COUNT read
// as zero.
module packed_10bit_field_store_top #(
  parameter int ENTRY_COUNT = 96,
  parameter int WORD_COUNT  = 32
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pfs_pkg::req_t in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pfs_pkg::rsp_t out_data_o
);
  import pfs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  // Sequencer
  pfs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // Store and field logic
  pfs_dpath #(
    .ENTRY_COUNT (ENTRY_COUNT),
    .WORD_COUNT  (WORD_COUNT)
  ) u_dpath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule
